// ===== rtl/gbfp_pkg.sv =====
// gbfp_pkg: shared types, constants and the CRC-32 byte update for the
// binary frame parser. No dependencies.
package gbfp_pkg;

    localparam int MAX_FRAME = 2048;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 11;
    localparam int LIMIT_W = 12;
    localparam int SUM_W   = 17;

    localparam logic [BYTE_W-1:0] SYNC_A     = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_B     = 8'h44;
    localparam logic [BYTE_W-1:0] KIND_SHORT = 8'hB5;
    localparam logic [BYTE_W-1:0] KIND_LONG  = 8'h12;

    localparam logic [4:0] HDR_SHORT = 5'd24;
    localparam logic [4:0] HDR_LONG  = 5'd28;

    localparam logic [IDX_W-1:0] ID_LO_POS     = 11'd4;
    localparam logic [IDX_W-1:0] ID_HI_POS     = 11'd5;
    localparam logic [IDX_W-1:0] LEN_POS_SHORT = 11'd6;
    localparam logic [IDX_W-1:0] LEN_POS_LONG  = 11'd8;

    localparam logic [31:0]        CRC_POLY    = 32'hEDB88320;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2000;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_W'(MAX_FRAME);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2,
        PH_TAIL = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              in_frame;
        logic [IDX_W-1:0]  byte_index;
        logic              frame_end;
        logic              crc_good;
        logic [15:0]       message_id;
        logic [IDX_W-1:0]  total_length;
        logic              long_header;
    } t_result;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [BYTE_W-1:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/gbfp_in_reg.sv =====
// gbfp_in_reg: input register for received bytes.
// Depends on gbfp_pkg.
module gbfp_in_reg
    import gbfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_take,
    output logic              o_word_valid,
    output logic [BYTE_W-1:0] o_word
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    assign o_stall      = r_valid && !i_take;
    assign accept       = i_valid && !o_stall;
    assign o_word_valid = r_valid;
    assign o_word       = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

// ===== rtl/gbfp_core.sv =====
// gbfp_core: frame state, header decode, length check and CRC-32 per byte.
// Depends on gbfp_pkg.
module gbfp_core
    import gbfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic               i_take,
    input  logic [BYTE_W-1:0]  i_byte,
    output t_result            o_result
);

    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_count, n_count;
    logic               r_long, n_long;
    logic [15:0]        r_id, n_id;
    logic [BYTE_W-1:0]  r_len_lo, n_len_lo;
    logic [IDX_W-1:0]   r_total, n_total;
    logic [31:0]        r_crc, n_crc;
    logic [31:0]        r_tail, n_tail;
    logic [LIMIT_W-1:0] r_limit;

    logic               sync0, sync1, sync2;
    logic [IDX_W-1:0]   lo_pos, count_inc;
    logic [4:0]         hdr_len;
    logic               len_hit, len_ok, body_done, tail_done;
    logic [SUM_W-1:0]   tot, min_tot;
    logic [LIMIT_W-1:0] limit_eff;
    logic [31:0]        crc_in, crc_next, tail_next;
    logic               kept;

    assign sync0     = (r_count == IDX_W'(0)) && (i_byte == SYNC_A);
    assign sync1     = (r_count == IDX_W'(1)) && (i_byte == SYNC_B);
    assign sync2     = (r_count == IDX_W'(2)) &&
                       ((i_byte == KIND_SHORT) || (i_byte == KIND_LONG));

    assign lo_pos    = r_long ? LEN_POS_LONG : LEN_POS_SHORT;
    assign hdr_len   = r_long ? HDR_LONG : HDR_SHORT;
    assign count_inc = r_count + IDX_W'(1);
    assign len_hit   = (r_count == lo_pos + IDX_W'(1));
    assign limit_eff = (r_limit > LIMIT_CAP) ? LIMIT_CAP : r_limit;
    assign tot       = SUM_W'({i_byte, r_len_lo}) + SUM_W'(hdr_len) + SUM_W'(4);
    assign min_tot   = SUM_W'(hdr_len) + SUM_W'(4);
    assign len_ok    = (tot > min_tot) && (tot < SUM_W'(limit_eff));
    assign body_done = (count_inc >= r_total - IDX_W'(4));
    assign tail_done = (count_inc >= r_total);

    assign crc_in    = ((r_phase == PH_HUNT) && (r_count == IDX_W'(0))) ? 32'd0 : r_crc;
    assign crc_next  = crc_byte(crc_in, i_byte);
    assign tail_next = {i_byte, r_tail[31:8]};

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: begin
                if (sync2) n_phase = PH_HEAD;
            end
            PH_HEAD: begin
                if (len_hit) n_phase = len_ok ? PH_BODY : PH_HUNT;
            end
            PH_BODY: begin
                if (body_done) n_phase = PH_TAIL;
            end
            PH_TAIL: begin
                if (tail_done) n_phase = PH_HUNT;
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        n_count  = r_count;
        n_long   = r_long;
        n_id     = r_id;
        n_len_lo = r_len_lo;
        n_total  = r_total;
        n_crc    = r_crc;
        n_tail   = r_tail;
        kept     = 1'b1;
        unique case (r_phase)
            PH_HUNT: begin
                if (sync0) begin
                    n_long   = 1'b0;
                    n_id     = '0;
                    n_len_lo = '0;
                    n_total  = '0;
                    n_tail   = '0;
                    n_crc    = crc_next;
                    n_count  = IDX_W'(1);
                end else if (sync1) begin
                    n_crc   = crc_next;
                    n_count = IDX_W'(2);
                end else if (sync2) begin
                    n_long  = (i_byte == KIND_LONG);
                    n_crc   = crc_next;
                    n_count = IDX_W'(3);
                end else begin
                    kept    = 1'b0;
                    n_count = '0;
                end
            end
            PH_HEAD: begin
                n_crc   = crc_next;
                n_count = count_inc;
                if (r_count == ID_LO_POS) begin
                    n_id = {8'd0, i_byte};
                end else if (r_count == ID_HI_POS) begin
                    n_id = {i_byte, r_id[7:0]};
                end
                if (r_count == lo_pos) begin
                    n_len_lo = i_byte;
                end else if (len_hit) begin
                    if (len_ok) begin
                        n_total = tot[IDX_W-1:0];
                    end else begin
                        n_count = '0;
                    end
                end
            end
            PH_BODY: begin
                n_crc   = crc_next;
                n_count = count_inc;
            end
            PH_TAIL: begin
                n_tail  = tail_next;
                n_count = tail_done ? '0 : count_inc;
            end
            default: n_count = '0;
        endcase

        o_result.data_out     = i_byte;
        o_result.in_frame     = kept;
        o_result.byte_index   = kept ? r_count : '0;
        o_result.frame_end    = (r_phase == PH_TAIL) && tail_done;
        o_result.crc_good     = (r_phase == PH_TAIL) && tail_done && (tail_next == r_crc);
        o_result.message_id   = kept ? n_id : '0;
        o_result.total_length = kept ? n_total : '0;
        o_result.long_header  = kept && (r_count >= IDX_W'(2)) && n_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_count  <= '0;
            r_long   <= 1'b0;
            r_id     <= '0;
            r_len_lo <= '0;
            r_total  <= '0;
            r_crc    <= '0;
            r_tail   <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_long   <= n_long;
            r_id     <= n_id;
            r_len_lo <= n_len_lo;
            r_total  <= n_total;
            r_crc    <= n_crc;
            r_tail   <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

endmodule

// ===== rtl/gbfp_out_reg.sv =====
// gbfp_out_reg: result register towards the consumer.
// Depends on gbfp_pkg.
module gbfp_out_reg
    import gbfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/gnss_binary_frame_parser_top.sv =====
// gnss_binary_frame_parser_top: byte-stream parser for CRC-32 binary frames.
// Depends on gbfp_pkg, gbfp_in_reg, gbfp_core, gbfp_out_reg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  input    | i_valid / o_stall   | i_rx_byte
//  result   | o_valid / i_stall   | o_data_out .. o_long_header
//  config   | i_cfg_wr_en         | i_cfg_wr_data (length limit)
//
// One word per cycle sustained while the result is not stalled; a word passes the
// input register, then the parse logic into the result register, before it is valid.
// Synchronous active-low reset clears frame state and sets the limit to 2000.
// A stalled result holds; o_stall rises only when both registers are full.
module gnss_binary_frame_parser_top
    import gbfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BYTE_W-1:0]  o_data_out,
    output logic               o_in_frame,
    output logic [IDX_W-1:0]   o_byte_index,
    output logic               o_frame_end,
    output logic               o_crc_good,
    output logic [15:0]        o_message_id,
    output logic [IDX_W-1:0]   o_total_length,
    output logic               o_long_header
);

    logic              word_valid;
    logic [BYTE_W-1:0] word;
    logic              out_ready;
    logic              take;
    t_result           core_result;
    t_result           out_result;

    assign take = word_valid && out_ready;

    gbfp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_take       (take),
        .o_word_valid (word_valid),
        .o_word       (word)
    );

    gbfp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_take        (take),
        .i_byte        (word),
        .o_result      (core_result)
    );

    gbfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_data_out     = out_result.data_out;
    assign o_in_frame     = out_result.in_frame;
    assign o_byte_index   = out_result.byte_index;
    assign o_frame_end    = out_result.frame_end;
    assign o_crc_good     = out_result.crc_good;
    assign o_message_id   = out_result.message_id;
    assign o_total_length = out_result.total_length;
    assign o_long_header  = out_result.long_header;

endmodule

// ===== rtl/gbfp_checker.sv =====
// gbfp_checker: port-level assertions for the frame parser, bound to the top.
// Depends on gbfp_pkg and gnss_binary_frame_parser_top.
module gbfp_checker
    import gbfp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [BYTE_W-1:0]  o_data_out,
    input logic               o_in_frame,
    input logic [IDX_W-1:0]   o_byte_index,
    input logic               o_frame_end,
    input logic               o_crc_good,
    input logic [15:0]        o_message_id,
    input logic [IDX_W-1:0]   o_total_length,
    input logic               o_long_header
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_out))
        else $error("result word dropped or changed under stall");

    a_not_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_frame |-> o_byte_index == '0 && o_message_id == '0 &&
            o_total_length == '0 && !o_long_header && !o_frame_end)
        else $error("status set on a dropped word");

    a_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_in_frame &&
            o_byte_index == o_total_length - IDX_W'(1))
        else $error("frame end not on last word of frame");

    a_good_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crc_good |-> o_frame_end)
        else $error("crc good without frame end");

endmodule

bind gnss_binary_frame_parser_top gbfp_checker u_gbfp_checker (.*);

// ===== dv/gbfp_frame_checker.sv =====
`timescale 1ns / 100ps
// gbfp_frame_checker: watches the byte and status channels of the frame parser,
// predicts every status word from its own copy of the parse state and compares.
// Depends on gbfp_pkg for widths, sync constants, t_phase and t_result.
module gbfp_frame_checker
    import gbfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [BYTE_W-1:0]  i_data_out,
    input  logic               i_in_frame,
    input  logic [IDX_W-1:0]   i_byte_index,
    input  logic               i_frame_end,
    input  logic               i_crc_good,
    input  logic [15:0]        i_message_id,
    input  logic [IDX_W-1:0]   i_total_length,
    input  logic               i_long_header,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_frames_closed,
    output int                 o_frames_good
);

    t_result            awaited_status[$];
    t_phase             ph;
    logic [IDX_W-1:0]   cnt;
    logic               kind_long;
    logic [15:0]        msg_id;
    logic [BYTE_W-1:0]  len_lo;
    logic [IDX_W-1:0]   frame_len;
    logic [31:0]        crc_acc;
    logic [31:0]        tail;
    logic [LIMIT_W-1:0] limit;

    initial begin
        o_mismatches    = 0;
        o_pending       = 0;
        o_frames_closed = 0;
        o_frames_good   = 0;
    end

    function automatic logic [31:0] crc32_next(input logic [31:0] acc,
                                               input logic [BYTE_W-1:0] d);
        logic [31:0] c;
        c = acc;
        for (int j = 0; j < 8; j++) begin
            if (c[0] ^ d[j]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic t_result predict_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        int      pos;
        int      lo_pos;
        int      hdr;
        int      tot;
        int      cap;
        bit      kept;
        bit      done;
        bit      good;
        pos  = int'(cnt);
        kept = 1'b1;
        done = 1'b0;
        good = 1'b0;
        case (ph)
            PH_HUNT: begin
                if (pos == 0 && b == SYNC_A) begin
                    kind_long = 1'b0;
                    msg_id    = '0;
                    len_lo    = '0;
                    frame_len = '0;
                    tail      = '0;
                    crc_acc   = crc32_next(32'd0, b);
                    cnt       = 11'd1;
                end else if (pos == 1 && b == SYNC_B) begin
                    crc_acc = crc32_next(crc_acc, b);
                    cnt     = 11'd2;
                end else if (pos == 2 && (b == KIND_SHORT || b == KIND_LONG)) begin
                    kind_long = (b == KIND_LONG);
                    crc_acc   = crc32_next(crc_acc, b);
                    cnt       = 11'd3;
                    ph        = PH_HEAD;
                end else begin
                    // dropped, not retried as a fresh sync
                    kept = 1'b0;
                    pos  = 0;
                    cnt  = '0;
                end
            end
            PH_HEAD: begin
                lo_pos  = kind_long ? int'(LEN_POS_LONG) : int'(LEN_POS_SHORT);
                crc_acc = crc32_next(crc_acc, b);
                if (pos == int'(ID_LO_POS)) begin
                    msg_id = {8'h00, b};
                end else if (pos == int'(ID_HI_POS)) begin
                    msg_id[15:8] = b;
                end
                if (pos == lo_pos) begin
                    len_lo = b;
                end else if (pos == lo_pos + 1) begin
                    hdr = kind_long ? int'(HDR_LONG) : int'(HDR_SHORT);
                    tot = int'({b, len_lo}) + hdr + 4;
                    cap = (int'(limit) > MAX_FRAME) ? MAX_FRAME : int'(limit);
                    if (tot > hdr + 4 && tot < cap) begin
                        frame_len = IDX_W'(tot);
                        ph        = PH_BODY;
                    end else begin
                        ph  = PH_HUNT;
                        cnt = '0;
                    end
                end
                if (ph != PH_HUNT) begin
                    cnt = IDX_W'(pos + 1);
                end
            end
            PH_BODY: begin
                crc_acc = crc32_next(crc_acc, b);
                cnt     = IDX_W'(pos + 1);
                if (int'(cnt) >= int'(frame_len) - 4) begin
                    ph = PH_TAIL;
                end
            end
            default: begin
                tail = {b, tail[31:8]};
                cnt  = IDX_W'(pos + 1);
                if (cnt >= frame_len) begin
                    done = 1'b1;
                    good = (tail == crc_acc);
                    ph   = PH_HUNT;
                    cnt  = '0;
                end
            end
        endcase
        r.data_out     = b;
        r.in_frame     = kept;
        r.byte_index   = kept ? IDX_W'(pos) : '0;
        r.frame_end    = done;
        r.crc_good     = good;
        r.message_id   = kept ? msg_id : '0;
        r.total_length = kept ? frame_len : '0;
        r.long_header  = (kept && pos >= 2) ? kind_long : 1'b0;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ph        = PH_HUNT;
            cnt       = '0;
            kind_long = 1'b0;
            msg_id    = '0;
            len_lo    = '0;
            frame_len = '0;
            crc_acc   = '0;
            tail      = '0;
            limit     = LIMIT_RESET;
            awaited_status.delete();
        end else begin
            if (i_cfg_wr_en) begin
                limit = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_status.size() == 0) begin
                    $error("status word 0x%0h with nothing awaited", i_data_out);
                    o_mismatches++;
                end else begin
                    want = awaited_status.pop_front();
                    check_field("data_out", 32'(want.data_out), 32'(i_data_out));
                    check_field("in_frame", 32'(want.in_frame), 32'(i_in_frame));
                    check_field("byte_index", 32'(want.byte_index), 32'(i_byte_index));
                    check_field("frame_end", 32'(want.frame_end), 32'(i_frame_end));
                    check_field("crc_good", 32'(want.crc_good), 32'(i_crc_good));
                    check_field("message_id", 32'(want.message_id), 32'(i_message_id));
                    check_field("total_length", 32'(want.total_length),
                                32'(i_total_length));
                    check_field("long_header", 32'(want.long_header),
                                32'(i_long_header));
                    if (want.frame_end) begin
                        o_frames_closed++;
                        if (want.crc_good) begin
                            o_frames_good++;
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_status.push_back(predict_byte(i_rx_byte));
            end
        end
        o_pending = awaited_status.size();
    end

endmodule

// ===== dv/gnss_binary_frame_parser_top_test.sv =====
`timescale 1ns / 100ps
// gnss_binary_frame_parser_top_test: drives byte streams and limit settings into
// the frame parser; gbfp_frame_checker predicts and compares every status word.
// Depends on gbfp_pkg, gnss_binary_frame_parser_top and gbfp_frame_checker.
module gnss_binary_frame_parser_top_test;
    import gbfp_pkg::*;

    localparam logic [BYTE_W-1:0] SYNC_SET[4] = '{SYNC_A, SYNC_B, KIND_SHORT, KIND_LONG};

    // sync slips, bad kind, zero payload, 0xFFFF payload
    localparam logic [BYTE_W-1:0] OPENING[25] = '{
        8'h00, 8'hFF,
        SYNC_A, SYNC_A,
        SYNC_A, SYNC_B, SYNC_B,
        SYNC_A, SYNC_B, KIND_SHORT, 8'h5A, 8'h34, 8'h12, 8'h00, 8'h00,
        SYNC_A, SYNC_B, KIND_LONG, 8'hA5, 8'hC3, 8'h3C, 8'h96, 8'h69, 8'hFF, 8'hFF
    };

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic [BYTE_W-1:0]  rx_byte     = '0;
    logic               out_stall   = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [BYTE_W-1:0]  res_data;
    logic               res_in_frame;
    logic [IDX_W-1:0]   res_index;
    logic               res_end;
    logic               res_crc_good;
    logic [15:0]        res_msg_id;
    logic [IDX_W-1:0]   res_total;
    logic               res_long;

    logic               in_taken = 1'b0;
    bit                 calm     = 1'b0;
    int                 words_sent = 0;
    int                 mismatches;
    int                 pending;
    int                 frames_closed;
    int                 frames_good;

    gnss_binary_frame_parser_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_rx_byte      (rx_byte),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_data_out     (res_data),
        .o_in_frame     (res_in_frame),
        .o_byte_index   (res_index),
        .o_frame_end    (res_end),
        .o_crc_good     (res_crc_good),
        .o_message_id   (res_msg_id),
        .o_total_length (res_total),
        .o_long_header  (res_long)
    );

    gbfp_frame_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_data_out      (res_data),
        .i_in_frame      (res_in_frame),
        .i_byte_index    (res_index),
        .i_frame_end     (res_end),
        .i_crc_good      (res_crc_good),
        .i_message_id    (res_msg_id),
        .i_total_length  (res_total),
        .i_long_header   (res_long),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_frames_closed (frames_closed),
        .o_frames_good   (frames_good)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        in_taken <= in_valid && !in_stall;
    end

    always @(negedge clk) begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
    end

    task automatic send_word(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(negedge clk); while (!in_taken);
        words_sent++;
    endtask

    // keep == 0 sends the whole frame, otherwise only its first keep bytes
    task automatic send_frame(input bit lng, input int payload, input bit spoil,
                              input int keep);
        logic [BYTE_W-1:0] f[$];
        logic [31:0]       c;
        int                hdr;
        int                lo;
        int                n;
        hdr = lng ? int'(HDR_LONG) : int'(HDR_SHORT);
        lo  = lng ? int'(LEN_POS_LONG) : int'(LEN_POS_SHORT);
        f.push_back(SYNC_A);
        f.push_back(SYNC_B);
        f.push_back(lng ? KIND_LONG : KIND_SHORT);
        for (int i = 3; i < hdr; i++) begin
            f.push_back(BYTE_W'($urandom_range(255)));
        end
        f[lo]     = payload[7:0];
        f[lo + 1] = payload[15:8];
        n = (payload < 300) ? payload : 300;
        for (int i = 0; i < n; i++) begin
            f.push_back(BYTE_W'($urandom_range(255)));
        end
        c = '0;
        foreach (f[i]) begin
            for (int j = 0; j < 8; j++) begin
                if (c[0] ^ f[i][j]) begin
                    c = (c >> 1) ^ CRC_POLY;
                end else begin
                    c = c >> 1;
                end
            end
        end
        if (spoil) begin
            c = c ^ (32'd1 << $urandom_range(31));
        end
        for (int i = 0; i < 4; i++) begin
            f.push_back(c[8*i +: 8]);
        end
        if (keep == 0 || keep > f.size()) begin
            keep = f.size();
        end
        for (int i = 0; i < keep; i++) begin
            send_word(f[i]);
        end
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int budget);
        int eff;
        int stop;
        int hdr;
        int room;
        int p;
        int r;
        bit lng;
        eff  = (int'(lim) > MAX_FRAME) ? MAX_FRAME : int'(lim);
        stop = words_sent + budget;
        // edges of the limit: one below accepted, at the limit rejected
        for (int k = 0; k < 2; k++) begin
            lng  = k[0];
            hdr  = lng ? int'(HDR_LONG) : int'(HDR_SHORT);
            room = eff - 1 - (hdr + 4);
            if (room >= 1 && room <= 300) begin
                send_frame(lng, room, 1'b0, 0);
            end
            send_frame(lng, (room + 1 > 0) ? room + 1 : 0, 1'b0,
                       (lng ? 10 : 8) + $urandom_range(0, 3));
        end
        while (words_sent < stop) begin
            lng  = 1'($urandom_range(1));
            hdr  = lng ? int'(HDR_LONG) : int'(HDR_SHORT);
            room = eff - 1 - (hdr + 4);
            p    = 0;
            if (room >= 1) begin
                p = ($urandom_range(99) < 85) ? $urandom_range(1, (room < 24) ? room : 24)
                                              : $urandom_range(1, (room < 250) ? room : 250);
            end
            r = $urandom_range(99);
            if (r < 60) begin
                send_frame(lng, p, 1'b0, 0);
            end else if (r < 70) begin
                send_frame(lng, p, 1'b1, 0);
            end else if (r < 80) begin
                p = $urandom_range(16'hFFFF);
                if (p >= 1 && p <= room) begin
                    p = 0;
                end
                send_frame(lng, p, 1'b0, (lng ? 10 : 8) + $urandom_range(0, 3));
            end else if (r < 88) begin
                send_frame(lng, p, 1'b0, $urandom_range(1, hdr + p + 3));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_word($urandom_range(1) ? SYNC_SET[$urandom_range(3)]
                                                : BYTE_W'($urandom_range(255)));
                end
            end
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] limits[7];
        int                 guard;
        limits = '{12'd33, LIMIT_CAP, 12'hFFF, 12'd0,
                   LIMIT_W'($urandom_range(34, 2047)), LIMIT_W'($urandom_range(34, 400)),
                   LIMIT_RESET};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (OPENING[i]) begin
            send_word(OPENING[i]);
        end
        foreach (limits[k]) begin
            write_limit(limits[k]);
            calm = (k == 6);
            run_phase(limits[k], 245);
        end
        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        $display("Covered %0d words over %0d limit settings (0, 33, 2048, 4095 among them);",
                 words_sent, 7);
        $display("%0d frames closed, %0d with matching CRC, %0d field mismatches.",
                 frames_closed, frames_good, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gbfp_pkg.sv
rtl/gbfp_in_reg.sv
rtl/gbfp_core.sv
rtl/gbfp_out_reg.sv
rtl/gnss_binary_frame_parser_top.sv
rtl/gbfp_checker.sv
dv/gbfp_frame_checker.sv
dv/gnss_binary_frame_parser_top_test.sv
